// ----- sv/sfm_pkg.sv -----
// Shared types and constants for the substring first-match finder.
`timescale 1ns / 1ps

package sfm_pkg;

  // Fixed register and field widths
  localparam int CFG_WIDTH       = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int LEN_REG_WIDTH   = 5;
  localparam int PAT_CAPACITY    = 16;
  localparam int START_WIDTH     = 16;

  typedef logic [7:0] byte_t;

  // Byte that terminates the text
  localparam byte_t END_BYTE = 8'h00;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  // Per-cycle control broadcast to every window cell
  typedef struct packed {
    logic shift;  // accepted a text byte: move the window along
    logic clear;  // accepted the end byte: empty the window
  } cell_ctl_t;

endpackage

// ----- sv/sfm_cell.sv -----
// One window cell: holds a text byte, passes it on and compares the incoming byte.
`timescale 1ns / 1ps

module sfm_cell (
  input  logic              clk,
  input  logic              rst,
  input  sfm_pkg::cell_ctl_t ctl,
  input  sfm_pkg::byte_t    byte_in,
  input  sfm_pkg::byte_t    pat_byte,
  input  logic              in_use,
  output sfm_pkg::byte_t    byte_out,
  output logic              eq
);
  import sfm_pkg::*;

  byte_t held;

  // Window storage, shifted from the left neighbor
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held <= END_BYTE;
    end else if (ctl.shift) begin
      held <= byte_in;
    end
  end

  // Compare against the byte this cell receives on the current shift
  assign eq       = !in_use || (byte_in == pat_byte);
  assign byte_out = held;

endmodule

// ----- sv/sfm_pattern.sv -----
// Pattern registers, effective length and per-cell aligned pattern bytes.
`timescale 1ns / 1ps

module sfm_pattern #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_BITS    = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sfm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [sfm_pkg::CFG_WIDTH-1:0]          cfg_data,
  output logic [LEN_BITS-1:0]                    eff_len,
  output logic [MAX_PATTERN-1:0][7:0]            cell_pat,
  output logic [MAX_PATTERN-1:0]                 cell_use
);
  import sfm_pkg::*;

  logic [CFG_WIDTH-1:0]     pattern_low;
  logic [CFG_WIDTH-1:0]     pattern_high;
  logic [LEN_REG_WIDTH-1:0] pattern_length;

  logic [PAT_CAPACITY-1:0][7:0] pat_bytes;
  logic [LEN_BITS-1:0]          len_clamped;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pattern_high, pattern_low};

  // Length clamped to the window size
  always_comb begin
    if (pattern_length > LEN_REG_WIDTH'(MAX_PATTERN)) begin
      len_clamped = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_clamped = LEN_BITS'(pattern_length);
    end
  end

  // Pattern stops at its first zero byte, like a C string
  always_comb begin
    eff_len = len_clamped;
    for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
      if ((i < int'(len_clamped)) && (pat_bytes[i] == END_BYTE)) begin
        eff_len = LEN_BITS'(i);
      end
    end
  end

  // Cell i sees the newest-but-i byte, so it checks pattern byte len-1-i
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cell_use[i] = (i < int'(eff_len));
      cell_pat[i] = END_BYTE;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (j == int'(eff_len) - 1 - i) begin
          cell_pat[i] = pat_bytes[j];
        end
      end
    end
  end

endmodule

// ----- sv/substring_first_match_finder.sv -----
// Top level of the streaming substring first-match finder.
//
// Usage: configure pattern_low, pattern_high and pattern_length through the
// write port (cfg_we, cfg_index, cfg_data) while the block is idle. Then send
// the text on the input channel (in_valid/in_ready, text_byte), one byte per
// request. A zero byte ends the text and yields one result request on the
// output channel (out_valid/out_ready, found, match_start, count_overflow).
// Non-zero bytes give no result.
// Throughput: one byte per cycle unless the output stalls, set by the window
// cell row, which shifts and compares every pattern position in the cycle
// a byte is accepted. Latency: the result is valid in the cycle after the
// end byte is accepted. The result sits in an output register; while it
// waits, in_ready stays high only if out_ready is high, so non-zero bytes
// stall too when the receiver stalls. After an end byte the window and
// counters clear at once. Reset (synchronous, rst) clears window, counters,
// the result valid flag and the pattern registers; no clearing pass is needed.
`timescale 1ns / 1ps

module substring_first_match_finder #(
  parameter int MAX_PATTERN = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sfm_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          text_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [sfm_pkg::START_WIDTH-1:0]     match_start,
  output logic                                count_overflow
);
  import sfm_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [LEN_BITS-1:0]         eff_len;
  logic [MAX_PATTERN-1:0][7:0] cell_pat;
  logic [MAX_PATTERN-1:0]      cell_use;
  logic [MAX_PATTERN:0][7:0]   chain;
  logic [MAX_PATTERN-1:0]      cell_eq;
  cell_ctl_t                   ctl;

  logic                  accept;
  logic                  is_end;
  logic                  window_match;
  logic [COUNT_BITS-1:0] bytes_seen;
  logic                  match_seen;
  logic [COUNT_BITS-1:0] first_start;
  logic                  saturated;
  logic [COUNT_BITS-1:0] len_minus_one;
  logic [COUNT_BITS-1:0] start_next;
  logic [32:0]           start_wide;
  logic [START_WIDTH-1:0] start_clamped;

  // Pattern registers and alignment
  sfm_pattern #(
    .MAX_PATTERN(MAX_PATTERN),
    .LEN_BITS   (LEN_BITS)
  ) u_pattern (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .eff_len  (eff_len),
    .cell_pat (cell_pat),
    .cell_use (cell_use)
  );

  // Handshake and cell control
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_end    = (text_byte == END_BYTE);
  assign ctl.shift = accept && !is_end;
  assign ctl.clear = accept && is_end;

  // Window cell row; cell 0 takes the new byte
  assign chain[0] = text_byte;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sfm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .byte_in (chain[g]),
      .pat_byte(cell_pat[g]),
      .in_use  (cell_use[g]),
      .byte_out(chain[g+1]),
      .eq      (cell_eq[g])
    );
  end

  assign window_match = &cell_eq;

  // Start offset of a match ending at the current byte
  assign len_minus_one = COUNT_BITS'(eff_len) - COUNT_BITS'(1);
  always_comb begin
    if (eff_len == '0) begin
      start_next = '0;
    end else if (bytes_seen >= len_minus_one) begin
      start_next = bytes_seen - len_minus_one;
    end else begin
      start_next = '0;
    end
  end

  // Position counter and first-match record
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      bytes_seen  <= '0;
      match_seen  <= 1'b0;
      first_start <= '0;
      saturated   <= 1'b0;
    end else if (ctl.shift) begin
      if (bytes_seen != COUNT_MAX) begin
        bytes_seen <= bytes_seen + COUNT_BITS'(1);
      end else begin
        saturated <= 1'b1;
      end
      if (!match_seen && window_match) begin
        match_seen  <= 1'b1;
        first_start <= start_next;
      end
    end
  end

  // Reported offset saturates at the field range
  assign start_wide = match_seen ? 33'(first_start) : 33'd0;
  assign start_clamped = (start_wide > 33'(16'hFFFF)) ? '1 : start_wide[START_WIDTH-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.clear) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      found          <= match_seen;
      match_start    <= start_clamped;
      count_overflow <= saturated;
    end
  end

`ifndef SYNTHESIS
  // End byte always produces a result in the next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> out_valid)
    else $error("end byte did not produce a result");

  // State is empty after the end of a text
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (bytes_seen == '0) && !match_seen && !saturated)
    else $error("state not cleared after end byte");

  // No match means offset zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_start == '0))
    else $error("nonzero offset without a match");

  // Saturation only with the counter at its top
  a_saturate_top: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (bytes_seen == COUNT_MAX))
    else $error("saturated flag set below counter top");
`endif

endmodule

// ----- tb/sfm_checker.sv -----
// Checker for the substring first-match finder: tracks the search state and checks each result.
`timescale 1ns / 1ps

module sfm_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sfm_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [7:0]                          text_byte,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                found,
  input  logic [sfm_pkg::START_WIDTH-1:0]     match_start,
  input  logic                                count_overflow,
  output int                                  errors,
  output int                                  pending
);
  import sfm_pkg::*;

  localparam int          WINDOW    = 16;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  typedef struct packed {
    logic                   found;
    logic [START_WIDTH-1:0] start;
    logic                   overflow;
  } search_result_t;

  // Shadow of the pattern registers
  logic [CFG_WIDTH-1:0]     pat_lo;
  logic [CFG_WIDTH-1:0]     pat_hi;
  logic [LEN_REG_WIDTH-1:0] pat_len;

  // Search state
  byte_t          window_q [WINDOW];
  logic [15:0]    bytes_seen;
  logic           hit_seen;
  logic [15:0]    hit_start;
  logic           saturated;
  search_result_t result_q[$];
  int             mismatches = 0;

  function automatic byte_t pat_byte(input int idx);
    logic [2*CFG_WIDTH-1:0] pat;
    pat = {pat_hi, pat_lo};
    return pat[8*idx +: 8];
  endfunction

  // Length in use: capped at the window size, cut at the first zero byte
  function automatic int pattern_span();
    int n;
    int i;
    n = (pat_len > WINDOW) ? WINDOW : int'(pat_len);
    for (i = 0; i < n; i++)
      if (pat_byte(i) == END_BYTE) return i;
    return n;
  endfunction

  function automatic void clear_search();
    int i;
    for (i = 0; i < WINDOW; i++) window_q[i] = '0;
    bytes_seen = '0;
    hit_seen   = 1'b0;
    hit_start  = '0;
    saturated  = 1'b0;
  endfunction

  // One accepted text byte; the end byte queues the result and clears the search
  function automatic void scan_byte(input byte_t b);
    int             span;
    int             pos;
    int             i;
    logic           eq;
    search_result_t r;
    span = pattern_span();
    if (b == END_BYTE) begin
      r.found    = hit_seen;
      r.start    = hit_seen ? hit_start : '0;
      r.overflow = saturated;
      result_q.push_back(r);
      clear_search();
    end else begin
      for (i = WINDOW - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = b;
      pos = int'(bytes_seen);
      if (bytes_seen != COUNT_TOP) bytes_seen++;
      else saturated = 1'b1;
      if (!hit_seen) begin
        eq = 1'b1;
        for (i = 0; i < span; i++)
          if (window_q[span-1-i] != pat_byte(i)) eq = 1'b0;
        if (eq) begin
          hit_seen = 1'b1;
          // empty pattern matches at once, at offset zero
          if (span == 0) hit_start = '0;
          else hit_start = (pos >= span - 1) ? 16'(pos - (span - 1)) : '0;
        end
      end
    end
  endfunction

  function automatic void report(input string what, input search_result_t want,
                                 input search_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected found=%0d start=%0d ovf=%0d, got found=%0d start=%0d ovf=%0d",
               $time, what, want.found, want.start, want.overflow,
               got.found, got.start, got.overflow);
  endfunction

  // Watch config writes, result requests and text requests
  always @(posedge clk) begin
    search_result_t want;
    search_result_t got;
    if (rst) begin
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = '0;
      clear_search();
      result_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_LOW:    pat_lo  = cfg_data;
          CFG_PATTERN_HIGH:   pat_hi  = cfg_data;
          CFG_PATTERN_LENGTH: pat_len = cfg_data[LEN_REG_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {found, match_start, count_overflow};
        if (result_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = result_q.pop_front();
          if (want != got) report("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) scan_byte(text_byte);
      pending <= result_q.size();
    end
    errors <= mismatches;
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the finder testbench: clock, reset, text and pattern stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
  import sfm_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 text_byte;
  logic                       out_valid;
  logic                       out_ready;
  logic                       found;
  logic [START_WIDTH-1:0]     match_start;
  logic                       count_overflow;

  int err_count;
  int pending;
  int sent    = 0;
  bit calm    = 1'b0;  // no idling on either side
  bit hold_go = 1'b0;  // asks the receiver for a long hold-off

  substring_first_match_finder u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .match_start(match_start), .count_overflow(count_overflow)
  );

  sfm_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .match_start(match_start), .count_overflow(count_overflow),
    .errors(err_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Overall time limit
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Starts and ends at a falling edge; valid stays up for the caller to keep or drop
  task automatic send_byte(input byte_t b);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input byte_t body[$]);
    foreach (body[i]) send_byte(body[i]);
    send_byte(END_BYTE);
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [CFG_WIDTH-1:0] lo, input logic [CFG_WIDTH-1:0] hi,
                              input logic [CFG_WIDTH-1:0] len_data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PATTERN_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data  <= len_data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic byte_t pick_letter();
    return byte_t'(8'h61 + $urandom_range(3));
  endfunction

  initial begin : stimulus
    byte_t                  txt[$];
    logic [CFG_WIDTH-1:0]   lo;
    logic [CFG_WIDTH-1:0]   hi;
    logic [CFG_WIDTH-1:0]   len_data;
    logic [2*CFG_WIDTH-1:0] pat_all;
    int                     base;
    int                     phase;
    int                     phase_end;
    int                     plen;
    int                     span_in;
    int                     cut;
    int                     style;
    int                     n;
    int                     at;
    int                     i;
    bit                     noise;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_PATTERN_LOW;
    cfg_data  = '0;
    in_valid  = 1'b0;
    text_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty pattern after reset: non-empty text hits at zero, empty text misses
    txt = {8'h61, 8'h62};
    send_text(txt);
    txt = {};
    send_text(txt);

    // Plain three-byte pattern, hit and partial miss
    load_pattern(64'h0000_0000_0063_6261, 64'h0, 64'd3);
    txt = {8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
    send_text(txt);
    txt = {8'h61, 8'h62};
    send_text(txt);

    // Full sixteen bytes of extreme values, length field above the cap
    load_pattern({8{8'hFF}}, {8{8'h01}}, {CFG_WIDTH{1'b1}});
    txt = {8'h01};
    repeat (8) txt.push_back(8'hFF);
    repeat (8) txt.push_back(8'h01);
    send_text(txt);

    // Zero byte inside the pattern cuts it short
    load_pattern(64'h0000_0000_6400_6261, 64'h0, 64'd4);
    txt = {8'h78, 8'h61, 8'h62};
    send_text(txt);

    // Leading zero byte makes the pattern empty
    load_pattern(64'h0000_0000_6162_6300, 64'h0, 64'd5);
    txt = {8'h71};
    send_text(txt);

    // Random phases: new pattern, then a batch of texts
    base = sent;
    for (phase = 0; sent - base < 780; phase++) begin
      plen  = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      style = $urandom_range(9);
      for (i = 0; i < 16; i++)
        pat_all[8*i +: 8] = (style == 0) ? byte_t'($urandom_range(1, 255)) : pick_letter();
      if (style == 1) pat_all[8*$urandom_range(15) +: 8] = END_BYTE;
      if (style == 2) pat_all = {$urandom, $urandom, $urandom, $urandom};
      lo       = pat_all[CFG_WIDTH-1:0];
      hi       = pat_all[2*CFG_WIDTH-1:CFG_WIDTH];
      len_data = ($urandom_range(1) == 1) ? {$urandom, $urandom} : '0;
      len_data[LEN_REG_WIDTH-1:0] = plen[LEN_REG_WIDTH-1:0];
      load_pattern(lo, hi, len_data);

      calm = (phase == 3);
      // receiver holds off while texts keep coming, so the block backs up
      if (phase == 1) hold_go = 1'b1;

      span_in   = (plen > 16) ? 16 : plen;
      phase_end = sent + $urandom_range(60, 140);
      while (sent < phase_end) begin
        txt   = {};
        n     = $urandom_range(0, 24);
        noise = ($urandom_range(9) < 2);
        for (i = 0; i < n; i++)
          txt.push_back(noise ? byte_t'($urandom_range(1, 255)) : pick_letter());
        if (!noise && $urandom_range(9) < 6) begin
          // whole pattern copy, sometimes only a prefix
          cut = ($urandom_range(3) == 0) ? $urandom_range(span_in) : span_in;
          at  = $urandom_range(n);
          for (i = 0; i < cut && pat_all[8*i +: 8] != END_BYTE; i++)
            txt.insert(at + i, pat_all[8*i +: 8]);
        end
        send_text(txt);
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
